FILE: src/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types, codes and constants of the grid A* path search block.
// ----------------------------------------------------------------------------
package gaps_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CRD_W   = 7;
  localparam int SCRD_W  = CRD_W + 2;
  localparam int POS_W   = 6;
  localparam int COST_W  = 20;
  localparam int OCC_W   = 8;
  localparam int XC_W    = 7;
  localparam int MAP_W   = OCC_W + XC_W;
  localparam int EXP_W   = 16;
  localparam int PLEN_W  = 13;
  localparam int ROOT_W  = CRD_W + 1;

  localparam logic [CRD_W-1:0] DEF_DIM       = 7'd64;
  localparam logic [CRD_W-1:0] DEF_THRESHOLD = 7'd40;
  localparam logic [COST_W-1:0] COST_MAX     = '1;
  localparam logic [EXP_W-1:0] EXP_MAX       = '1;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_DIAGONAL    = 2'd2,
    REG_THRESHOLD   = 2'd3
  } reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDD,
    S_START,
    S_CLR,
    S_INIT,
    S_SCAN,
    S_PICK,
    S_NB,
    S_NBW,
    S_NBE,
    S_W1,
    S_W1W,
    S_W2,
    S_W2W,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [COST_W-1:0] g;
    logic [COST_W-1:0] f;
    logic              open_m;
    logic              closed_m;
    logic [2:0]        dir;
  } node_t;

  localparam int NODE_W = $bits(node_t);

  localparam logic signed [1:0] DX [8] = '{2'sd0, 2'sd1, 2'sd0, -2'sd1,
                                           2'sd1, -2'sd1, 2'sd1, -2'sd1};
  localparam logic signed [1:0] DY [8] = '{2'sd1, 2'sd0, -2'sd1, 2'sd0,
                                           2'sd1, 2'sd1, -2'sd1, -2'sd1};

endpackage

FILE: src/gaps_if.sv
// ----------------------------------------------------------------------------
// gaps_if
// Handshake channels of the grid A* path search block.
// ----------------------------------------------------------------------------
interface gaps_req_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [11:0]       cell_index;
  logic signed [7:0] occupancy;
  logic [6:0]        extra_cost;
  logic [5:0]        start_x;
  logic [5:0]        start_y;
  logic [5:0]        goal_x;
  logic [5:0]        goal_y;
  logic [11:0]       path_step;

  modport source (output valid, cmd, cell_index, occupancy, extra_cost, start_x, start_y,
                  goal_x, goal_y, path_step, input ready);
  modport sink (input valid, cmd, cell_index, occupancy, extra_cost, start_x, start_y,
                goal_x, goal_y, path_step, output ready);
endinterface

interface gaps_rsp_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [12:0] path_length;
  logic [15:0] expansions;
  logic [5:0]  path_x;
  logic [5:0]  path_y;

  modport source (output valid, found, path_length, expansions, path_x, path_y, input ready);
  modport sink (input valid, found, path_length, expansions, path_x, path_y, output ready);
endinterface

interface gaps_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [6:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/grid_astar_path_search.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search
// A* path search over an occupancy grid held in on-chip RAM.
// ----------------------------------------------------------------------------
// A load word writes one map cell if its index is in range and registers its
// response on the accepting edge, so loads stream at one per cycle while the
// response register drains. A read word registers its response from the path
// RAM read data in S_RDD. A search word runs to completion before the next word
// is taken: the node RAM is cleared over all n cells (n = width * height), then
// for each expanded cell a scan finds the open cell of least estimate and each
// in-grid neighbour is read and, if free, updated (in diagonal mode after the
// bit-serial square root), and finally the path is traced back from the goal and
// stored. Scan, neighbour and trace phases wait on the single node RAM read port.
// ----------------------------------------------------------------------------
module grid_astar_path_search #(
  parameter int MAX_WIDTH  = gaps_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = gaps_pkg::DEF_MAX_HEIGHT
) (
  input logic        clk,
  input logic        rst,
  gaps_req_if.sink   req,
  gaps_rsp_if.source rsp,
  gaps_cfg_if.sink   cfg
);
  import gaps_pkg::*;

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int CW    = $clog2(CELLS);
  localparam int NW    = CW + 1;

  state_t state, state_next;

  logic [CRD_W-1:0] grid_width, grid_height, blocked_threshold;
  logic             diagonal_mode;

  logic [CRD_W-1:0] wid, hgt, wid_eff, hgt_eff;
  logic [CRD_W-1:0] sx, sy, gx, gy;
  logic [NW-1:0]    n_cells;

  logic             found_flag;
  logic [NW-1:0]    path_count;
  logic [EXP_W-1:0] expansions;

  logic             res_valid, res_found;
  logic [PLEN_W-1:0] res_len;
  logic [EXP_W-1:0] res_exp;
  logic [POS_W-1:0] res_x, res_y;
  logic             rd_ok;

  logic [CW-1:0]    clr_i;
  logic [NW-1:0]    scan_i;
  logic [CRD_W-1:0] scan_x, scan_y, rd_x, rd_y;
  logic             rd_pend;
  logic [CW-1:0]    rd_i;
  logic             pick_valid;
  logic [CW-1:0]    pick_i;
  logic [CRD_W-1:0] pick_x, pick_y;
  node_t            pick_node;

  logic [CRD_W-1:0]  cur_x, cur_y;
  logic [COST_W-1:0] cur_g;
  logic [3:0]        dir_i;
  logic [CW-1:0]     ni;
  logic [CRD_W-1:0]  ax, ay;
  logic [CRD_W-1:0]  wx, wy;
  logic [NW-1:0]     wlen;

  logic          node_we, node_re;
  logic [CW-1:0] node_waddr, node_raddr;
  node_t         node_wdata, node_rd;
  logic [NODE_W-1:0] node_rdata;
  logic          map_we, map_re;
  logic [CW-1:0] map_waddr, map_raddr;
  logic [MAP_W-1:0] map_wdata, map_rdata;
  logic          path_we, path_re;
  logic [CW-1:0] path_waddr, path_raddr;
  logic [2*POS_W-1:0] path_wdata, path_rdata;

  logic              sq_start, sq_busy;
  logic [ROOT_W-1:0] sq_root;

  logic [CRD_W-1:0]   idx_x, idx_y;
  logic [2*CRD_W-1:0] idx_full;
  logic [CW-1:0]      idx;

  logic              accept, produce;
  cmd_t              cmd;
  logic [3:0]        nd;
  logic              dir_end, nb_in, at_goal, at_start, off_grid, clr_done;
  logic signed [SCRD_W-1:0] nx_s, ny_s;
  logic [CRD_W-1:0]  nb_x, nb_y;
  logic signed [OCC_W-1:0] occ;
  logic              blocked, nb_ok, nb_upd, sq_wait;
  logic [COST_W-1:0] gv, fv;
  logic [ROOT_W-1:0] hv;
  logic [CRD_W-1:0]  wx_prev, wy_prev;

  gaps_ram #(.WIDTH(MAP_W), .DEPTH(CELLS)) u_map_ram (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .re(map_re), .raddr(map_raddr), .rdata(map_rdata)
  );

  gaps_ram #(.WIDTH(NODE_W), .DEPTH(CELLS)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
  );

  gaps_ram #(.WIDTH(2 * POS_W), .DEPTH(CELLS)) u_path_ram (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .re(path_re), .raddr(path_raddr), .rdata(path_rdata)
  );

  gaps_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .ax(ax), .ay(ay),
    .busy(sq_busy), .root(sq_root)
  );

  assign cfg.ready = 1'b1;
  assign req.ready = (state == S_IDLE) && (!res_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign cmd       = cmd_t'(req.cmd);

  assign rsp.valid       = res_valid;
  assign rsp.found       = res_found;
  assign rsp.path_length = res_len;
  assign rsp.expansions  = res_exp;
  assign rsp.path_x      = res_x;
  assign rsp.path_y      = res_y;

  assign node_rd = node_t'(node_rdata);

  always_comb begin
    wid_eff = grid_width;
    if (grid_width == '0) begin
      wid_eff = CRD_W'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      wid_eff = CRD_W'(MAX_WIDTH);
    end
    hgt_eff = grid_height;
    if (grid_height == '0) begin
      hgt_eff = CRD_W'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      hgt_eff = CRD_W'(MAX_HEIGHT);
    end
  end

  always_comb begin
    nd       = diagonal_mode ? 4'd8 : 4'd4;
    dir_end  = (dir_i == nd);
    nx_s     = $signed({2'b00, cur_x}) + SCRD_W'(DX[dir_i[2:0]]);
    ny_s     = $signed({2'b00, cur_y}) + SCRD_W'(DY[dir_i[2:0]]);
    nb_in    = !nx_s[SCRD_W-1] && !ny_s[SCRD_W-1] &&
               (nx_s < $signed({2'b00, wid})) && (ny_s < $signed({2'b00, hgt}));
    nb_x     = nx_s[CRD_W-1:0];
    nb_y     = ny_s[CRD_W-1:0];
    at_goal  = (cur_x == gx) && (cur_y == gy);
    at_start = (wx == sx) && (wy == sy);
    off_grid = (sx >= wid) || (sy >= hgt) || (gx >= wid) || (gy >= hgt);
    clr_done = ({1'b0, clr_i} == n_cells - NW'(1));

    occ      = $signed(map_rdata[MAP_W-1:XC_W]);
    blocked  = occ[OCC_W-1] || (occ > $signed({1'b0, blocked_threshold}));
    nb_ok    = !blocked && !node_rd.closed_m;
    gv       = cur_g + COST_W'(1) + COST_W'(map_rdata[XC_W-1:0]);
    hv       = diagonal_mode ? sq_root : ({1'b0, ax} + {1'b0, ay});
    fv       = gv + COST_W'(hv);
    nb_upd   = gv < node_rd.g;
    sq_wait  = diagonal_mode && sq_busy;

    wx_prev  = CRD_W'($signed({2'b00, wx}) - SCRD_W'(DX[node_rd.dir]));
    wy_prev  = CRD_W'($signed({2'b00, wy}) - SCRD_W'(DY[node_rd.dir]));
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && cmd == CMD_SEARCH) begin
          state_next = S_START;
        end else if (accept && cmd == CMD_READ) begin
          state_next = S_RDD;
        end
      end
      S_RDD:   state_next = S_IDLE;
      S_START: state_next = off_grid ? S_FIN : S_CLR;
      S_CLR:   state_next = clr_done ? S_INIT : S_CLR;
      S_INIT:  state_next = ((sx == gx) && (sy == gy)) ? S_W1 : S_SCAN;
      S_SCAN: begin
        if (scan_i == n_cells && !rd_pend) begin
          state_next = S_PICK;
        end
      end
      S_PICK:  state_next = pick_valid ? S_NB : S_FIN;
      S_NB: begin
        if (dir_end) begin
          state_next = at_goal ? S_W1 : S_SCAN;
        end else if (nb_in) begin
          state_next = S_NBW;
        end
      end
      S_NBW:   state_next = S_NBE;
      S_NBE:   state_next = sq_wait ? S_NBE : S_NB;
      S_W1:    state_next = (at_start || wlen >= n_cells) ? S_W2 : S_W1W;
      S_W1W:   state_next = S_W1;
      S_W2:    state_next = (wlen == '0) ? S_FIN : S_W2W;
      S_W2W:   state_next = S_W2;
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    idx_x      = wx;
    idx_y      = wy;
    map_we     = 1'b0;
    map_waddr  = CW'(req.cell_index);
    map_wdata  = {req.occupancy, req.extra_cost};
    map_re     = 1'b0;
    node_we    = 1'b0;
    node_waddr = idx;
    node_wdata = '{g: COST_MAX, f: COST_MAX, open_m: 1'b0, closed_m: 1'b0, dir: 3'd0};
    node_re    = 1'b0;
    path_we    = 1'b0;
    path_waddr = CW'(wlen - NW'(1));
    path_wdata = {wy[POS_W-1:0], wx[POS_W-1:0]};
    path_re    = 1'b0;
    path_raddr = CW'(req.path_step);
    sq_start   = 1'b0;
    case (state)
      S_IDLE: begin
        map_we  = accept && cmd == CMD_LOAD && (32'(req.cell_index) < CELLS);
        path_re = accept && cmd == CMD_READ;
      end
      S_CLR: begin
        node_we    = 1'b1;
        node_waddr = clr_i;
      end
      S_INIT: begin
        idx_x      = sx;
        idx_y      = sy;
        node_we    = 1'b1;
        node_wdata = '{g: '0, f: COST_MAX, open_m: 1'b1, closed_m: 1'b0, dir: 3'd0};
      end
      S_SCAN: begin
        node_re = scan_i < n_cells;
      end
      S_PICK: begin
        node_we    = pick_valid;
        node_waddr = pick_i;
        node_wdata = pick_node;
        node_wdata.closed_m = 1'b1;
      end
      S_NB: begin
        idx_x   = nb_x;
        idx_y   = nb_y;
        node_re = !dir_end && nb_in;
        map_re  = !dir_end && nb_in;
      end
      S_NBW: begin
        sq_start = diagonal_mode;
      end
      S_NBE: begin
        node_we    = !sq_wait && nb_ok;
        node_waddr = ni;
        if (nb_upd) begin
          node_wdata = '{g: gv, f: fv, open_m: 1'b1, closed_m: 1'b0, dir: dir_i[2:0]};
        end else begin
          node_wdata = node_rd;
          node_wdata.open_m = 1'b1;
        end
      end
      S_W1: begin
        node_re = !(at_start || wlen >= n_cells);
      end
      S_W2: begin
        node_re = wlen != '0;
      end
      S_W2W: begin
        path_we = 1'b1;
      end
      default: begin
      end
    endcase
    idx_full = {{CRD_W{1'b0}}, idx_y} * {{CRD_W{1'b0}}, wid} + {{CRD_W{1'b0}}, idx_x};
    idx      = CW'(idx_full);
    node_raddr = (state == S_SCAN) ? scan_i[CW-1:0] : idx;
    map_raddr  = idx;
  end

  assign produce = (state == S_IDLE && accept && (cmd == CMD_LOAD || cmd == CMD_NOP)) ||
                   state == S_RDD || state == S_FIN;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      grid_width        <= DEF_DIM;
      grid_height       <= DEF_DIM;
      diagonal_mode     <= 1'b0;
      blocked_threshold <= DEF_THRESHOLD;
      found_flag        <= 1'b0;
      path_count        <= '0;
      expansions        <= '0;
      res_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        case (reg_t'(cfg.index))
          REG_GRID_WIDTH:  grid_width        <= cfg.data;
          REG_GRID_HEIGHT: grid_height       <= cfg.data;
          REG_DIAGONAL:    diagonal_mode     <= cfg.data[0];
          REG_THRESHOLD:   blocked_threshold <= cfg.data;
          default: begin
          end
        endcase
      end
      if (state == S_IDLE && accept && cmd == CMD_SEARCH) begin
        found_flag <= 1'b0;
        path_count <= '0;
        expansions <= '0;
      end
      if (state_next == S_W1 && state != S_W1 && state != S_W1W) begin
        found_flag <= 1'b1;
      end
      if (state == S_W1 && state_next == S_W2) begin
        path_count <= wlen;
      end
      if (state == S_NBE && !sq_wait && nb_ok && expansions != EXP_MAX) begin
        expansions <= expansions + EXP_W'(1);
      end
      if (produce) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      res_found <= found_flag;
      res_len   <= PLEN_W'(path_count);
      res_exp   <= expansions;
      res_x     <= (state == S_RDD && rd_ok) ? path_rdata[POS_W-1:0] : '0;
      res_y     <= (state == S_RDD && rd_ok) ? path_rdata[2*POS_W-1:POS_W] : '0;
    end
    if (state != S_SCAN && state_next == S_SCAN) begin
      scan_i     <= '0;
      scan_x     <= '0;
      scan_y     <= '0;
      rd_pend    <= 1'b0;
      pick_valid <= 1'b0;
    end
    if (state_next == S_W1 && state != S_W1 && state != S_W1W) begin
      wx   <= gx;
      wy   <= gy;
      wlen <= '0;
    end
    case (state)
      S_IDLE: begin
        if (accept && cmd == CMD_SEARCH) begin
          wid <= wid_eff;
          hgt <= hgt_eff;
          sx  <= CRD_W'(req.start_x);
          sy  <= CRD_W'(req.start_y);
          gx  <= CRD_W'(req.goal_x);
          gy  <= CRD_W'(req.goal_y);
        end
        rd_ok <= 32'(req.path_step) < 32'(path_count);
      end
      S_START: begin
        n_cells <= NW'({{CRD_W{1'b0}}, wid} * {{CRD_W{1'b0}}, hgt});
        clr_i   <= '0;
      end
      S_CLR: begin
        clr_i <= clr_i + CW'(1);
      end
      S_SCAN: begin
        if (scan_i < n_cells) begin
          scan_i <= scan_i + NW'(1);
          if (scan_x == wid - CRD_W'(1)) begin
            scan_x <= '0;
            scan_y <= scan_y + CRD_W'(1);
          end else begin
            scan_x <= scan_x + CRD_W'(1);
          end
        end
        rd_pend <= scan_i < n_cells;
        rd_i    <= scan_i[CW-1:0];
        rd_x    <= scan_x;
        rd_y    <= scan_y;
        if (rd_pend && node_rd.open_m && !node_rd.closed_m &&
            (!pick_valid || node_rd.f < pick_node.f)) begin
          pick_valid <= 1'b1;
          pick_i     <= rd_i;
          pick_x     <= rd_x;
          pick_y     <= rd_y;
          pick_node  <= node_rd;
        end
      end
      S_PICK: begin
        cur_x <= pick_x;
        cur_y <= pick_y;
        cur_g <= pick_node.g;
        dir_i <= '0;
      end
      S_NB: begin
        if (!dir_end) begin
          if (nb_in) begin
            ni <= idx;
            ax <= (nb_x > gx) ? nb_x - gx : gx - nb_x;
            ay <= (nb_y > gy) ? nb_y - gy : gy - nb_y;
          end else begin
            dir_i <= dir_i + 4'd1;
          end
        end
      end
      S_NBE: begin
        if (!sq_wait) begin
          dir_i <= dir_i + 4'd1;
        end
      end
      S_W1: begin
        if (state_next == S_W2) begin
          wx <= gx;
          wy <= gy;
        end
      end
      S_W1W: begin
        wx   <= wx_prev;
        wy   <= wy_prev;
        wlen <= wlen + NW'(1);
      end
      S_W2W: begin
        wx   <= wx_prev;
        wy   <= wy_prev;
        wlen <= wlen - NW'(1);
      end
      default: begin
      end
    endcase
  end

  a_scan_read_only: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> !node_we)
    else $error("node write during open-set scan");

  a_lost_empty: assert property (@(posedge clk) disable iff (rst)
    !found_flag |-> path_count == '0)
    else $error("path length without a found path");

  a_pick_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK && pick_valid) |-> (pick_node.open_m && !pick_node.closed_m))
    else $error("expanded cell not in open set");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |->
      ($past(state) == S_IDLE || $past(state) == S_RDD || $past(state) == S_FIN))
    else $error("response raised outside a finishing state");

endmodule

FILE: src/gaps_ram.sv
// ----------------------------------------------------------------------------
// gaps_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/gaps_isqrt.sv
// ----------------------------------------------------------------------------
// gaps_isqrt
// Iterative floor square root of ax*ax + ay*ay, one result bit per cycle.
// ----------------------------------------------------------------------------
module gaps_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gaps_pkg::CRD_W-1:0]  ax,
  input  logic [gaps_pkg::CRD_W-1:0]  ay,
  output logic                        busy,
  output logic [gaps_pkg::ROOT_W-1:0] root
);
  import gaps_pkg::*;

  localparam int VW = 2 * ROOT_W;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [VW-1:0]    rem;
  logic [VW-1:0]    res;
  logic [VW-1:0]    one;
  logic [VW-1:0]    trial;
  logic [CNT_W-1:0] cnt;

  assign trial = res + one;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(ROOT_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= VW'(ax) * VW'(ax) + VW'(ay) * VW'(ay);
      res <= '0;
      one <= VW'(1) << (VW - 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + one;
      end else begin
        res <= res >> 1;
      end
      one <= one >> 2;
    end
  end

endmodule
